FILE: rtl/hdrtm_pkg.sv
package hdrtm_pkg;

    localparam int Channels = 3;
    localparam int MagWidth = 15;
    localparam int CodeWidth = 8;
    localparam int CodeCount = 255;
    localparam logic [MagWidth-1:0] MagInf = 15'h7C00;
    localparam logic [4:0] ExpAllOnes = 5'h1F;

    typedef struct packed {
        logic [Channels-1:0][MagWidth-1:0]  mag;
        logic [Channels-1:0][CodeWidth-1:0] code;
        logic                               last;
    } t_pix;

    // Exact code of a nonnegative half magnitude, positive infinity included.
    // The code is the largest c with c^11 * D^5 <= 255^11 * N^5, where N/D = x/(1+x).
    function automatic logic [CodeWidth-1:0] code_of(input logic [MagWidth-1:0] mag);
        logic [4:0]   ex;
        logic [10:0]  mant;
        logic [4:0]   scale;
        logic [31:0]  num;
        logic [31:0]  den;
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] d5;
        logic [7:0]   code;
        logic [7:0]   cand;
        int           i;
        int           b;
        ex = mag[14:10];
        if (ex == ExpAllOnes) begin
            return 8'd255;
        end
        mant  = (ex != 5'd0) ? {1'b1, mag[9:0]} : {1'b0, mag[9:0]};
        scale = (ex != 5'd0) ? ex : 5'd1;
        if (scale < 5'd25) begin
            num = {21'd0, mant};
            den = (32'd1 << (5'd25 - scale)) + num;
        end else begin
            num = {21'd0, mant} << (scale - 5'd25);
            den = num + 32'd1;
        end
        rhs = 256'd1;
        for (i = 0; i < 11; i++) rhs = rhs * 256'd255;
        for (i = 0; i < 5; i++) rhs = rhs * {224'd0, num};
        d5 = 256'd1;
        for (i = 0; i < 5; i++) d5 = d5 * {224'd0, den};
        code = 8'd0;
        for (b = 7; b >= 0; b--) begin
            cand = code | (8'd1 << b);
            lhs = d5;
            for (i = 0; i < 11; i++) lhs = lhs * {248'd0, cand};
            if (lhs <= rhs) code = cand;
        end
        return code;
    endfunction

    // Entry c-1 is the smallest magnitude whose code is at least c.
    function automatic logic [CodeCount-1:0][MagWidth-1:0] build_thresh();
        logic [CodeCount-1:0][MagWidth-1:0] tab;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] mid;
        int          c;
        int          s;
        for (c = 1; c <= CodeCount; c++) begin
            lo = 16'd0;
            hi = {1'b0, MagInf};
            for (s = 0; s < 16; s++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    if (code_of(mid[MagWidth-1:0]) >= 8'(c)) hi = mid;
                    else lo = mid + 16'd1;
                end
            end
            tab[c-1] = lo[MagWidth-1:0];
        end
        return tab;
    endfunction

    localparam logic [CodeCount-1:0][MagWidth-1:0] ThreshTab = build_thresh();

endpackage

FILE: rtl/hdr_half_tonemap_to_rgb8.sv
// Channel | Signals                                             | Direction
// input   | i_valid, o_ready, i_{red,green,blue}_half, i_last_pixel | in
// output  | o_valid, i_ready, o_{red,green,blue}_code, o_frame_end  | out
//
// One pixel per clock enters when the output side keeps up.
// The pipeline has one decode stage and eight search stages, one code bit each.
// Each search stage compares each channel against one entry of a 255-entry constant threshold table.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// A stall backs up stage by stage; no transfer is lost or repeated.
module hdr_half_tonemap_to_rgb8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_red_half,
    input  logic [15:0] i_green_half,
    input  logic [15:0] i_blue_half,
    input  logic        i_last_pixel,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red_code,
    output logic [7:0]  o_green_code,
    output logic [7:0]  o_blue_code,
    output logic        o_frame_end
);
    import hdrtm_pkg::*;

    localparam int Steps = CodeWidth;

    logic [Steps:0] v;
    logic [Steps:0] rdy;
    t_pix           pix [Steps+1];

    hdrtm_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red_half   (i_red_half),
        .i_green_half (i_green_half),
        .i_blue_half  (i_blue_half),
        .i_last_pixel (i_last_pixel),
        .o_valid      (v[0]),
        .i_ready      (rdy[0]),
        .o_pix        (pix[0])
    );

    for (genvar s = 0; s < Steps; s++) begin : g_step
        hdrtm_step #(.BIT_POS(Steps - 1 - s)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[s]),
            .o_ready (rdy[s]),
            .i_pix   (pix[s]),
            .o_valid (v[s+1]),
            .i_ready (rdy[s+1]),
            .o_pix   (pix[s+1])
        );
    end

    assign rdy[Steps]   = i_ready;
    assign o_valid      = v[Steps];
    assign o_red_code   = pix[Steps].code[0];
    assign o_green_code = pix[Steps].code[1];
    assign o_blue_code  = pix[Steps].code[2];
    assign o_frame_end  = pix[Steps].last;

    a_reset: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (pix[Steps].mag[0] == '0) |-> o_red_code == '0)
        else $error("zero red magnitude gave a nonzero code");

    a_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (pix[Steps].mag[1] == MagInf) |-> o_green_code == 8'hFF)
        else $error("infinite green gave a code below full scale");

endmodule

FILE: rtl/hdrtm_decode.sv
module hdrtm_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_red_half,
    input  logic [15:0]          i_green_half,
    input  logic [15:0]          i_blue_half,
    input  logic                 i_last_pixel,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hdrtm_pkg::t_pix      o_pix
);
    import hdrtm_pkg::*;

    logic                          r_valid;
    t_pix                          r_pix;
    t_pix                          n_pix;
    logic [Channels-1:0][15:0]     halves;

    assign halves  = {i_blue_half, i_green_half, i_red_half};
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_pix   = r_pix;

    // Negative values and NaN map to magnitude zero, which yields code zero.
    always_comb begin
        n_pix.last = i_last_pixel;
        for (int c = 0; c < Channels; c++) begin
            n_pix.code[c] = '0;
            if (halves[c][15] || (halves[c][14:0] > MagInf)) begin
                n_pix.mag[c] = '0;
            end else begin
                n_pix.mag[c] = halves[c][14:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_pix <= n_pix;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_pix))
        else $error("decode stage lost a stalled pixel");

    a_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_pix.code == '0) && (r_pix.mag[0] <= MagInf)
            && (r_pix.mag[1] <= MagInf) && (r_pix.mag[2] <= MagInf))
        else $error("decode stage produced an out-of-range magnitude");

endmodule

FILE: rtl/hdrtm_step.sv
module hdrtm_step #(
    parameter int BIT_POS = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  hdrtm_pkg::t_pix      i_pix,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hdrtm_pkg::t_pix      o_pix
);
    import hdrtm_pkg::*;

    localparam logic [CodeWidth-1:0] StepBit = CodeWidth'(1) << BIT_POS;
    localparam logic [CodeWidth-1:0] LowMask = StepBit - CodeWidth'(1);

    logic   r_valid;
    t_pix   r_pix;
    t_pix   n_pix;
    logic [Channels-1:0][CodeWidth-1:0] cand;
    logic [Channels-1:0][CodeWidth-1:0] idx;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_pix   = r_pix;

    // One bit of a binary search over the monotonic threshold table.
    always_comb begin
        n_pix = i_pix;
        for (int c = 0; c < Channels; c++) begin
            cand[c] = i_pix.code[c] | StepBit;
            idx[c]  = cand[c] - CodeWidth'(1);
            if (i_pix.mag[c] >= ThreshTab[idx[c]]) begin
                n_pix.code[c] = cand[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_pix <= n_pix;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_pix))
        else $error("search stage lost a stalled pixel");

    a_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_pix.code[0] & LowMask) == '0) && ((r_pix.code[1] & LowMask) == '0)
            && ((r_pix.code[2] & LowMask) == '0))
        else $error("search stage set a bit ahead of its turn");

endmodule

FILE: tb/pixel_code_checker.sv
`timescale 1ns / 100ps

module pixel_code_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [15:0] i_red_half,
    input  logic [15:0] i_green_half,
    input  logic [15:0] i_blue_half,
    input  logic        i_last_pixel,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_red_code,
    input  logic [7:0]  o_green_code,
    input  logic [7:0]  o_blue_code,
    input  logic        o_frame_end,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_codes;

    t_codes expected_pixels[$];

    function automatic logic [255:0] raise(input logic [255:0] base, input int n);
        logic [255:0] acc;
        acc = 256'd1;
        repeat (n) acc = acc * base;
        return acc;
    endfunction

    // Largest code c with (c/255)^2.2 <= x/(1+x), decided in exact integers.
    function automatic logic [7:0] tonemap_channel(input logic [15:0] half);
        logic [4:0]   expo;
        logic [9:0]   frac;
        logic [31:0]  mant;
        int           shift;
        logic [31:0]  num;
        logic [31:0]  den;
        logic [255:0] bound;
        logic [255:0] den_pow;
        logic [7:0]   code;
        logic [7:0]   trial;
        expo = half[14:10];
        frac = half[9:0];
        if (half[15]) return 8'd0;
        if (expo == 5'h1F) return (frac != 10'd0) ? 8'd0 : 8'd255;
        mant  = (expo != 5'd0) ? {21'd0, 1'b1, frac} : {22'd0, frac};
        shift = (expo != 5'd0) ? int'(expo) : 1;
        if (shift < 25) begin
            num = mant;
            den = (32'd1 << (25 - shift)) + mant;
        end else begin
            num = mant << (shift - 25);
            den = num + 32'd1;
        end
        bound   = raise(256'd255, 11) * raise({224'd0, num}, 5);
        den_pow = raise({224'd0, den}, 5);
        code = 8'd0;
        for (int b = 7; b >= 0; b--) begin
            trial = code | (8'd1 << b);
            if (raise({248'd0, trial}, 11) * den_pow <= bound) code = trial;
        end
        return code;
    endfunction

    assign o_pending = expected_pixels.size();

    always @(posedge i_clk) begin
        t_codes want;
        int     errors;
        errors = 0;
        if (i_rst_n && i_valid && o_ready) begin
            want.red       = tonemap_channel(i_red_half);
            want.green     = tonemap_channel(i_green_half);
            want.blue      = tonemap_channel(i_blue_half);
            want.frame_end = i_last_pixel;
            expected_pixels.push_back(want);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("Output transfer with no pixel pending");
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_red_code !== want.red) begin
                    $error("red_code: expected %0d, got %0d", want.red, o_red_code);
                    errors++;
                end
                if (o_green_code !== want.green) begin
                    $error("green_code: expected %0d, got %0d", want.green, o_green_code);
                    errors++;
                end
                if (o_blue_code !== want.blue) begin
                    $error("blue_code: expected %0d, got %0d", want.blue, o_blue_code);
                    errors++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, o_frame_end);
                    errors++;
                end
            end
        end
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else if (errors != 0) begin
            o_fail_count <= o_fail_count + errors;
        end
    end

endmodule

FILE: tb/hdr_half_tonemap_to_rgb8_tb.sv
`timescale 1ns / 100ps

module hdr_half_tonemap_to_rgb8_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_red_half = '0;
    logic [15:0] i_green_half = '0;
    logic [15:0] i_blue_half = '0;
    logic        i_last_pixel = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_red_code;
    logic [7:0]  o_green_code;
    logic [7:0]  o_blue_code;
    logic        o_frame_end;
    int          fail_count;
    int          pending;
    int          stall_asked = 0;
    int          stall_done = 0;
    logic        sender_steady = 1'b0;
    logic        receiver_steady = 1'b0;

    localparam int NumRandom = 1500;
    localparam int LongStall = 200;

    always #5 i_clk = ~i_clk;

    hdr_half_tonemap_to_rgb8 uut (.*);

    pixel_code_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_red_half, .i_green_half,
        .i_blue_half, .i_last_pixel, .o_valid, .i_ready, .o_red_code,
        .o_green_code, .o_blue_code, .o_frame_end,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_length(input logic steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called right after a rising edge; returns right after the edge of the transfer.
    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input logic last);
        int   gap;
        logic taken;
        gap = gap_length(sender_steady);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_red_half   <= r;
        i_green_half <= g;
        i_blue_half  <= b;
        i_last_pixel <= last;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    function automatic logic [15:0] random_half();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 16'($urandom_range(16'h0000, 16'h7BFF));
        if (r < 65) return 16'($urandom_range(16'h3000, 16'h4C00));
        if (r < 75) return 16'($urandom_range(16'h0000, 16'h03FF));
        if (r < 80) return $urandom_range(0, 1) ? 16'h7C00 : 16'hFC00;
        return 16'($urandom());
    endfunction

    always @(posedge i_clk) begin
        int hold;
        if (stall_done < stall_asked) begin
            hold = LongStall;
            i_ready <= 1'b0;
            while (hold > 0) begin
                @(posedge i_clk);
                hold--;
            end
            stall_done <= stall_done + 1;
        end else if (receiver_steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : ($urandom_range(0, 19) == 0);
        end
    end

    initial begin
        logic [15:0] corner[$];
        int          wait_cycles;
        logic        drained;
        corner = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFE00,
                   16'h7C01, 16'h7BFF, 16'hFBFF, 16'h0001, 16'h03FF, 16'h0400,
                   16'h3C00, 16'hBC00, 16'h3BFF, 16'h5BFF, 16'h7FFF, 16'hFFFF};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (corner[k]) begin
            send_pixel(corner[k], corner[(k + 5) % corner.size()],
                       corner[(k + 11) % corner.size()], k[0]);
        end
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
        for (int n = 0; n < NumRandom; n++) begin
            if (n % 150 == 0) begin
                sender_steady   <= ($urandom_range(0, 2) == 0);
                receiver_steady <= ($urandom_range(0, 2) == 0);
            end
            if (n == 300 || n == 900) stall_asked <= stall_asked + 1;
            if (n == 600) begin
                i_valid <= 1'b0;
                do begin
                    @(negedge i_clk);
                    drained = (pending == 0);
                    @(posedge i_clk);
                end while (!drained);
            end
            send_pixel(random_half(), random_half(), random_half(),
                       ($urandom_range(0, 15) == 0));
        end
        i_valid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
